### rtl/multiturn_angle_velocity_tracker_top_assert.svh
// assertion macros used by the tracker checker
`ifndef MULTITURN_ANGLE_VELOCITY_TRACKER_TOP_ASSERT_SVH
`define MULTITURN_ANGLE_VELOCITY_TRACKER_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define MAVT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mavt assertion failed");

// next-cycle implication, disabled while reset is low
`define MAVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mavt assertion failed");

`endif

### rtl/mavt_pkg.sv
// shared types and constants of the multi-turn angle and velocity tracker
package mavt_pkg;

    // op codes of an input item
    localparam logic [1:0] OP_UPDATE   = 2'd0;
    localparam logic [1:0] OP_VELOCITY = 2'd1;
    localparam logic [1:0] OP_INIT     = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL   = 2'd1;

    // fixed field widths
    localparam int unsigned WRAP_W     = 14;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned TURN_OUT_W = 32;
    localparam int unsigned POS_W      = 46;
    localparam int unsigned VEL_W      = 48;

    // register reset values
    localparam logic [WRAP_W-1:0] WRAP_RESET         = 14'd13107;
    localparam logic [TIME_W-1:0] MIN_INTERVAL_RESET = 32'd1000;

    // microseconds per second, multiplied in one bit per cycle
    localparam int unsigned USEC_W = 20;
    localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;

    // velocity saturation limits
    localparam logic [VEL_W-1:0] VEL_POS_LIM = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VEL_NEG_LIM = {1'b1, {(VEL_W-1){1'b0}}};

    // velocity unit response
    typedef struct packed {
        logic             done;
        logic [VEL_W-1:0] vel;
    } t_vel_rsp;

endpackage

### rtl/mavt_vel_unit.sv
// iterative velocity unit: shift-add multiply by 1e6, restoring divide, saturate
module mavt_vel_unit #(
    parameter int unsigned ANGLE_BITS = 14,
    parameter int unsigned TURN_BITS  = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [TURN_BITS+ANGLE_BITS:0]  i_num,
    input  logic [mavt_pkg::TIME_W-1:0]           i_dt,
    output mavt_pkg::t_vel_rsp                    o_rsp
);

    localparam int unsigned NUM_W  = TURN_BITS + ANGLE_BITS + 1;
    localparam int unsigned MAG_W  = NUM_W - 1;
    localparam int unsigned PROD_W = MAG_W + mavt_pkg::USEC_W;
    localparam int unsigned CNT_W  = $clog2(PROD_W);
    localparam int unsigned MIDX_W = $clog2(mavt_pkg::USEC_W);
    localparam int unsigned SAT_W  = (PROD_W > mavt_pkg::VEL_W) ? PROD_W : mavt_pkg::VEL_W;
    localparam int unsigned TW     = mavt_pkg::TIME_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS,
        S_MUL,
        S_DIV,
        S_SAT
    } t_state;

    t_state                      r_state;
    logic [CNT_W-1:0]            r_cnt;
    logic signed [NUM_W-1:0]     r_num;
    logic                        r_neg;
    logic [MAG_W-1:0]            r_mag;
    logic [TW-1:0]               r_dt;
    logic [PROD_W-1:0]           r_acc;
    logic [TW-1:0]               r_rem;
    logic                        r_done;
    logic [mavt_pkg::VEL_W-1:0]  r_vel;

    logic [TW:0]                 w_rem_sh;
    logic                        w_ge;
    logic [PROD_W-1:0]           w_addend;
    logic [mavt_pkg::VEL_W-1:0]  w_lim;
    logic                        w_over;
    logic [mavt_pkg::VEL_W-1:0]  w_sat;

    // multiplier bit selects whether the magnitude is added this step
    assign w_addend = mavt_pkg::USEC_PER_SEC[r_cnt[MIDX_W-1:0]] ? PROD_W'(r_mag)
                                                                : '0;

    // restoring divide step
    assign w_rem_sh = {r_rem, r_acc[PROD_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_dt};

    // saturation of the quotient
    assign w_lim  = r_neg ? mavt_pkg::VEL_NEG_LIM : mavt_pkg::VEL_POS_LIM;
    assign w_over = SAT_W'(r_acc) > SAT_W'(w_lim);
    assign w_sat  = w_over ? w_lim : mavt_pkg::VEL_W'(r_acc);

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_num   <= i_num;
                        r_dt    <= i_dt;
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_neg   <= r_num[NUM_W-1];
                    r_mag   <= r_num[NUM_W-1] ? MAG_W'(-r_num) : MAG_W'(r_num);
                    r_acc   <= '0;
                    r_cnt   <= CNT_W'(mavt_pkg::USEC_W - 1);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_acc <= {r_acc[PROD_W-2:0], 1'b0} + w_addend;
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(PROD_W - 1);
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? TW'(w_rem_sh - {1'b0, r_dt}) : TW'(w_rem_sh);
                    r_acc <= {r_acc[PROD_W-2:0], w_ge};
                    if (r_cnt == '0) begin
                        r_state <= S_SAT;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_SAT: begin
                    r_vel   <= r_neg ? (mavt_pkg::VEL_W'(0) - w_sat) : w_sat;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.vel  = r_vel;

endmodule

### rtl/multiturn_angle_velocity_tracker_top.sv
// multi-turn angle and velocity tracker top level
// Tracks a single-turn absolute angle plus a signed turn count and answers velocity
// queries in counts per second (2^ANGLE_BITS counts per turn). An angle update, a
// baseline load or an unused op produces its result item the cycle after it is
// accepted. A velocity query runs through one iterative unit: a shift-add multiply
// by 10^6 and a restoring divide by the microsecond delta, one quotient bit per
// cycle over TURN_BITS+ANGLE_BITS+20 bits, with setup before them and saturation
// after. One item is in work at a time; the next item is taken as soon as the
// previous result is being taken.
module multiturn_angle_velocity_tracker_top #(
    parameter int unsigned ANGLE_BITS = 14,
    parameter int unsigned TURN_BITS  = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mavt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mavt_pkg::TIME_W-1:0]           i_cfg_data,
    // input item channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_op,
    input  logic [7:0]                            i_angle_high_byte,
    input  logic [7:0]                            i_angle_low_byte,
    input  logic [mavt_pkg::TIME_W-1:0]           i_timestamp_us,
    // result item channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [ANGLE_BITS-1:0]                 o_mech_angle,
    output logic signed [mavt_pkg::TURN_OUT_W-1:0] o_turn_count,
    output logic signed [mavt_pkg::POS_W-1:0]     o_position_counts,
    output logic signed [mavt_pkg::VEL_W-1:0]     o_velocity_cps,
    output logic                                  o_velocity_valid
);

    localparam int unsigned NUM_W = TURN_BITS + ANGLE_BITS + 1;
    localparam int unsigned CMP_W = (ANGLE_BITS > mavt_pkg::WRAP_W) ? ANGLE_BITS
                                                                     : mavt_pkg::WRAP_W;
    localparam int unsigned TW    = mavt_pkg::TIME_W;

    typedef enum logic {
        S_IDLE,
        S_VEL
    } t_state;

    t_state                      r_state;
    logic                        r_out_valid;
    logic [mavt_pkg::VEL_W-1:0]  r_vel;
    logic                        r_vvalid;

    logic [mavt_pkg::WRAP_W-1:0] r_wrap;
    logic [TW-1:0]               r_min_int;

    logic [ANGLE_BITS-1:0]       r_angle_now;
    logic [TURN_BITS-1:0]        r_turns_now;
    logic [TW-1:0]               r_time_now;
    logic [ANGLE_BITS-1:0]       r_angle_base;
    logic [TURN_BITS-1:0]        r_turns_base;
    logic [TW-1:0]               r_time_base;

    logic                        w_accept;
    logic [ANGLE_BITS-1:0]       w_code;
    logic signed [ANGLE_BITS:0]  w_d;
    logic [ANGLE_BITS-1:0]       w_ad;
    logic                        w_wrap;
    logic [TURN_BITS-1:0]        w_turns_upd;
    logic [TURN_BITS-1:0]        w_dturn;
    logic signed [ANGLE_BITS:0]  w_dangle;
    logic signed [NUM_W-1:0]     w_num;
    logic [TW-1:0]               w_dtd;
    logic [TW-1:0]               w_dt;
    mavt_pkg::t_vel_rsp          w_rsp;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall));
    assign w_accept    = i_in_valid && !o_in_stall;

    // angle code from the top bits of the raw register word
    assign w_code = ANGLE_BITS'({i_angle_high_byte, i_angle_low_byte} >> (16 - ANGLE_BITS));

    // wrap detection against the current angle
    assign w_d    = $signed({1'b0, w_code}) - $signed({1'b0, r_angle_now});
    assign w_ad   = w_d[ANGLE_BITS] ? ANGLE_BITS'(-w_d) : ANGLE_BITS'(w_d);
    assign w_wrap = CMP_W'(w_ad) > CMP_W'(r_wrap);
    assign w_turns_upd = !w_wrap ? r_turns_now
                       : (w_d[ANGLE_BITS] ? r_turns_now + TURN_BITS'(1)
                                          : r_turns_now - TURN_BITS'(1));

    // velocity numerator and time delta
    assign w_dturn  = r_turns_now - r_turns_base;
    assign w_dangle = $signed({1'b0, r_angle_now}) - $signed({1'b0, r_angle_base});
    assign w_num    = $signed({w_dturn[TURN_BITS-1], w_dturn, {ANGLE_BITS{1'b0}}})
                    + NUM_W'(w_dangle);
    assign w_dtd    = r_time_now - r_time_base;
    assign w_dt     = (w_dtd != '0)     ? w_dtd
                    : (r_min_int != '0) ? r_min_int : TW'(1);

    mavt_vel_unit #(
        .ANGLE_BITS (ANGLE_BITS),
        .TURN_BITS  (TURN_BITS)
    ) u_vel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept && (i_op == mavt_pkg::OP_VELOCITY)),
        .i_num   (w_num),
        .i_dt    (w_dt),
        .o_rsp   (w_rsp)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap    <= mavt_pkg::WRAP_RESET;
            r_min_int <= mavt_pkg::MIN_INTERVAL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == mavt_pkg::CFG_WRAP_THRESHOLD) begin
                r_wrap <= i_cfg_data[mavt_pkg::WRAP_W-1:0];
            end else if (i_cfg_index == mavt_pkg::CFG_MIN_INTERVAL) begin
                r_min_int <= i_cfg_data;
            end
        end
    end

    // op sequencing, tracker state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_vvalid     <= 1'b0;
            r_vel        <= '0;
            r_angle_now  <= '0;
            r_turns_now  <= '0;
            r_time_now   <= '0;
            r_angle_base <= '0;
            r_turns_base <= '0;
            r_time_base  <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_vel    <= '0;
                        r_vvalid <= 1'b0;
                        unique case (i_op)
                            mavt_pkg::OP_UPDATE: begin
                                r_angle_now <= w_code;
                                r_time_now  <= i_timestamp_us;
                                r_turns_now <= w_turns_upd;
                                r_out_valid <= 1'b1;
                            end
                            mavt_pkg::OP_VELOCITY: begin
                                r_state <= S_VEL;
                            end
                            mavt_pkg::OP_INIT: begin
                                r_angle_now  <= w_code;
                                r_angle_base <= w_code;
                                r_time_now   <= i_timestamp_us;
                                r_time_base  <= i_timestamp_us;
                                r_out_valid  <= 1'b1;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_VEL: begin
                    if (w_rsp.done) begin
                        r_vel        <= w_rsp.vel;
                        r_vvalid     <= 1'b1;
                        r_out_valid  <= 1'b1;
                        r_angle_base <= r_angle_now;
                        r_turns_base <= r_turns_now;
                        r_time_base  <= r_time_now;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result fields
    assign o_out_valid       = r_out_valid;
    assign o_mech_angle      = r_angle_now;
    assign o_turn_count      = mavt_pkg::TURN_OUT_W'($signed(r_turns_now));
    assign o_position_counts = mavt_pkg::POS_W'($signed({r_turns_now, r_angle_now}));
    assign o_velocity_cps    = r_vel;
    assign o_velocity_valid  = r_vvalid;

endmodule

### rtl/mavt_checker.sv
// port-level checker for the tracker top and its bind
`include "multiturn_angle_velocity_tracker_top_assert.svh"

module mavt_checker #(
    parameter int unsigned ANGLE_BITS = 14
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic [1:0]                             i_op,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic [ANGLE_BITS-1:0]                  o_mech_angle,
    input logic signed [mavt_pkg::POS_W-1:0]      o_position_counts,
    input logic signed [mavt_pkg::VEL_W-1:0]      o_velocity_cps,
    input logic                                   o_velocity_valid
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    // a stalled result item holds
    `MAVT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_velocity_cps) && $stable(o_position_counts))

    // no new item while a result is blocked
    `MAVT_ASSERT_IMPLY(a_no_accept_blocked, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)

    // an angle update answers next cycle without a velocity
    `MAVT_ASSERT_NEXT(a_update_result, i_clk, i_rst_n, w_in_acc && (i_op == mavt_pkg::OP_UPDATE), o_out_valid && !o_velocity_valid)

    // a velocity query keeps the block busy
    `MAVT_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, w_in_acc && (i_op == mavt_pkg::OP_VELOCITY), o_in_stall && !o_out_valid)

    // position low bits are the single-turn angle
    `MAVT_ASSERT_IMPLY(a_pos_angle, i_clk, i_rst_n, o_out_valid, o_position_counts[ANGLE_BITS-1:0] == o_mech_angle)

endmodule

bind multiturn_angle_velocity_tracker_top mavt_checker #(
    .ANGLE_BITS (ANGLE_BITS)
) u_mavt_checker (.*);
